>>> src/npt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_pkg
// shared types and constants for the trial division prime engine
// ----------------------------------------------------------------------------
package npt_pkg;

	localparam int VALUE_BITS = 31;
	localparam int CNT_BITS   = $clog2(VALUE_BITS);

	typedef enum logic {
		FUNC_TEST = 1'b0,
		FUNC_NEXT = 1'b1
	} func_t;

	typedef struct packed {
		logic                  func;
		logic [VALUE_BITS-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic                  is_prime_flag;
		logic [VALUE_BITS-1:0] result_value;
		logic                  overflow;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_WAIT,
		ST_VERDICT
	} state_t;

endpackage

>>> src/npt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_div
// restoring divider, one quotient bit per cycle, quotient and remainder
// ----------------------------------------------------------------------------
module npt_div import npt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output logic                  done,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [VALUE_BITS-1:0] remainder
);

	logic                  run_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS:0]   diff;
	logic                  fits;

	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = !diff[VALUE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_BITS'(VALUE_BITS - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], fits};
			rem_q <= fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> src/next_prime_trial_division.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_prime_trial_division
// primality test and next prime search by trial division over odd divisors
// ----------------------------------------------------------------------------
// channel   signals              transfer
// command   start, busy, cmd     edge with start high and busy low
// result    done, result         edge ending the single cycle done is high
//
// each divisor trial starts the shared bit-serial divider in ST_DIV and
// waits in ST_WAIT; a candidate passes ST_CHECK, its trials and ST_VERDICT,
// and a next prime search repeats that for each candidate tried.
// busy stays high from the command transfer until the result is registered.
// reset clears the sequencer; no result is pending after reset.
// the receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module next_prime_trial_division import npt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	state_t                state_q, state_d;
	logic                  func_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [VALUE_BITS:0]   cand_q;
	logic [VALUE_BITS-1:0] d_q;
	logic                  prime_q;
	logic                  done_q;
	result_t               result_q;

	logic                  div_start;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quo;
	logic [VALUE_BITS-1:0] div_rem;

	logic                  accept;
	logic                  d_init;
	logic                  d_step;
	logic                  set_prime;
	logic                  prime_val;
	logic                  cand_inc;
	logic                  finish;
	result_t               result_d;

	assign accept = start && !busy;

	npt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (cand_q[VALUE_BITS-1:0]),
		.divisor   (d_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (cand_q[VALUE_BITS]) state_d = ST_IDLE;
				else if (cand_q[VALUE_BITS:1] == '0 || !cand_q[0]) state_d = ST_VERDICT;
				else state_d = ST_DIV;
			end
			ST_DIV: begin
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_done) begin
					if (d_q > div_quo || div_rem == '0) state_d = ST_VERDICT;
					else state_d = ST_DIV;
				end
			end
			ST_VERDICT: begin
				if (func_q == FUNC_TEST || prime_q) state_d = ST_IDLE;
				else state_d = ST_CHECK;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		div_start = 1'b0;
		d_init    = 1'b0;
		d_step    = 1'b0;
		set_prime = 1'b0;
		prime_val = 1'b0;
		cand_inc  = 1'b0;
		finish    = 1'b0;
		result_d  = '0;
		case (state_q)
			ST_CHECK: begin
				if (cand_q[VALUE_BITS]) begin
					finish            = 1'b1;
					result_d.overflow = 1'b1;
				end else if (cand_q[VALUE_BITS:1] == '0) begin
					set_prime = 1'b1;
				end else if (!cand_q[0]) begin
					set_prime = 1'b1;
					prime_val = (cand_q[VALUE_BITS:1] == (VALUE_BITS)'(1));
				end else begin
					d_init = 1'b1;
				end
			end
			ST_DIV: begin
				div_start = 1'b1;
			end
			ST_WAIT: begin
				if (div_done) begin
					if (d_q > div_quo) begin
						set_prime = 1'b1;
						prime_val = 1'b1;
					end else if (div_rem == '0) begin
						set_prime = 1'b1;
					end else begin
						d_step = 1'b1;
					end
				end
			end
			ST_VERDICT: begin
				if (func_q == FUNC_TEST) begin
					finish                 = 1'b1;
					result_d.is_prime_flag = prime_q;
					result_d.result_value  = value_q;
				end else if (prime_q) begin
					finish                 = 1'b1;
					result_d.is_prime_flag = 1'b1;
					result_d.result_value  = cand_q[VALUE_BITS-1:0];
				end else begin
					cand_inc = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= cmd.func;
			value_q <= cmd.value;
			cand_q  <= (cmd.func == FUNC_NEXT) ? ({1'b0, cmd.value} + 1'b1) : {1'b0, cmd.value};
		end else if (cand_inc) begin
			cand_q <= cand_q + 1'b1;
		end
		if (d_init) d_q <= (VALUE_BITS)'(3);
		else if (d_step) d_q <= d_q + (VALUE_BITS)'(2);
		if (set_prime) prime_q <= prime_val;
		if (finish) result_q <= result_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.overflow |-> result.result_value == '0 && !result.is_prime_flag)
		else $error("overflow result carries data");
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("command transfer did not raise busy");
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> div_rem < d_q) else $error("divider remainder not below divisor");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the trial division prime engine
// ----------------------------------------------------------------------------
// every accepted command is run through a behavioral prime predictor and the
// expected result is queued; each done strobe is compared field by field with
// the oldest queued result. directed edge values for both operations come
// first, then back-to-back commands, then a random mix of small, medium and
// cheap large operands with random sender gaps. large operands are kept to
// values with a small factor so the run length stays bounded.
// ----------------------------------------------------------------------------
module tb_top import npt_pkg::*; ();

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    done;
	result_t result;

	result_t pending_results[$];
	int      errors;
	int      results_checked;
	int      n_test;
	int      n_next;
	int      n_overflow;
	int      n_prime;

	next_prime_trial_division i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	function automatic bit is_prime_u(longint unsigned n);
		longint unsigned d;
		if (n < 2) return 1'b0;
		if (n == 2) return 1'b1;
		if (n[0] == 1'b0) return 1'b0;
		for (d = 3; d <= n / d; d += 2) begin
			if (n % d == 0) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic result_t prime_answer(cmd_t c);
		result_t         r;
		longint unsigned lim;
		longint unsigned cand;
		lim = (64'd1 << VALUE_BITS) - 1;
		r   = '0;
		if (func_t'(c.func) == FUNC_TEST) begin
			r.is_prime_flag = is_prime_u(64'(c.value));
			r.result_value  = c.value;
		end else begin
			cand = 64'(c.value) + 1;
			while (cand <= lim && !is_prime_u(cand)) cand++;
			if (cand > lim) begin
				r.overflow = 1'b1;
			end else begin
				r.is_prime_flag = 1'b1;
				r.result_value  = cand[VALUE_BITS-1:0];
			end
		end
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40) return 0;
		if (sel < 85) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_cmd(input func_t f, input logic [VALUE_BITS-1:0] v,
			input bit with_gaps);
		cmd_t    c;
		result_t r;
		int      gap;
		c.func  = f;
		c.value = v;
		@(negedge clk);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		r = prime_answer(c);
		pending_results.push_back(r);
		if (f == FUNC_TEST) n_test++;
		else n_next++;
		if (r.overflow) n_overflow++;
		if (r.is_prime_flag) n_prime++;
		gap = with_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_primality_edges();
		send_cmd(FUNC_TEST, 31'd0, 1'b1);
		send_cmd(FUNC_TEST, 31'd1, 1'b1);
		send_cmd(FUNC_TEST, 31'd2, 1'b1);
		send_cmd(FUNC_TEST, 31'd3, 1'b1);
		send_cmd(FUNC_TEST, 31'd4, 1'b1);
		// odd squares hit the divisor bound exactly
		send_cmd(FUNC_TEST, 31'd9, 1'b1);
		send_cmd(FUNC_TEST, 31'd25, 1'b1);
		send_cmd(FUNC_TEST, 31'd1018081, 1'b1);
		send_cmd(FUNC_TEST, 31'd65521, 1'b1);
		send_cmd(FUNC_TEST, VALUE_MAX - 31'd1, 1'b1);
		send_cmd(FUNC_TEST, VALUE_MAX - 31'd2, 1'b1);
		send_cmd(FUNC_TEST, 31'h4000_0000, 1'b1);
		wait_drained();
	endtask

	task automatic test_next_prime_edges();
		send_cmd(FUNC_NEXT, 31'd0, 1'b1);
		send_cmd(FUNC_NEXT, 31'd1, 1'b1);
		send_cmd(FUNC_NEXT, 31'd2, 1'b1);
		send_cmd(FUNC_NEXT, 31'd7, 1'b1);
		send_cmd(FUNC_NEXT, 31'd8, 1'b1);
		send_cmd(FUNC_NEXT, 31'd14, 1'b1);
		send_cmd(FUNC_NEXT, 31'd23, 1'b1);
		send_cmd(FUNC_NEXT, 31'd65521, 1'b1);
		send_cmd(FUNC_NEXT, 31'd1018080, 1'b1);
		// no prime above the top value
		send_cmd(FUNC_NEXT, VALUE_MAX, 1'b1);
		wait_drained();
	endtask

	task automatic test_back_to_back();
		repeat (20) begin
			send_cmd(func_t'($urandom_range(0, 1)), 31'($urandom_range(0, 4095)), 1'b0);
		end
		wait_drained();
	endtask

	task automatic test_random_mix();
		func_t                 f;
		logic [VALUE_BITS-1:0] v;
		int                    sel;
		int unsigned           d;
		repeat (60) begin
			sel = $urandom_range(0, 99);
			f   = func_t'($urandom_range(0, 1));
			if (sel < 65) begin
				v = 31'($urandom_range(0, 4095));
			end else if (sel < 80) begin
				v = 31'($urandom_range(0, (1 << 20) - 1));
			end else if (sel < 95) begin
				// large operands only with a small factor
				f = FUNC_TEST;
				if ($urandom_range(0, 1)) begin
					v = 31'($urandom()) & ~31'd1;
				end else begin
					d = 2 * $urandom_range(1, 11) + 1;
					v = 31'(64'(d) * $urandom_range(1, VALUE_MAX / d));
				end
			end else begin
				f = FUNC_NEXT;
				v = VALUE_MAX;
			end
			send_cmd(f, v, 1'b1);
		end
		wait_drained();
	endtask

	always @(posedge clk) begin : result_check
		result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%t unexpected result: actual %p", $time, result);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				results_checked++;
				if (result.is_prime_flag !== exp_r.is_prime_flag) begin
					$display("%t is_prime_flag mismatch: expected %0b actual %0b",
						$time, exp_r.is_prime_flag, result.is_prime_flag);
					errors++;
				end
				if (result.result_value !== exp_r.result_value) begin
					$display("%t result_value mismatch: expected %0d actual %0d",
						$time, exp_r.result_value, result.result_value);
					errors++;
				end
				if (result.overflow !== exp_r.overflow) begin
					$display("%t overflow mismatch: expected %0b actual %0b",
						$time, exp_r.overflow, result.overflow);
					errors++;
				end
			end
		end
	end

	initial begin
		#200_000_000;
		$display("%t timeout with %0d results pending", $time, pending_results.size());
		$display("[next_prime_trial_division] ERROR");
		$finish;
	end

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		start           = 1'b0;
		cmd             = '0;
		errors          = 0;
		results_checked = 0;
		n_test          = 0;
		n_next          = 0;
		n_overflow      = 0;
		n_prime         = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_primality_edges();
		test_next_prime_edges();
		test_back_to_back();
		test_random_mix();

		repeat (40) @(posedge clk);
		$display("commands: %0d primality tests, %0d next prime searches",
			n_test, n_next);
		$display("results checked: %0d, prime flags: %0d, overflows: %0d, errors: %0d",
			results_checked, n_prime, n_overflow, errors);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("[next_prime_trial_division] OK");
		end else begin
			$display("[next_prime_trial_division] ERROR");
		end
		$finish;
	end

endmodule
